FILE: hdl/fan_tach_stall_monitor_top_assert.svh
// ----------------------------------------------------------------------------
// Fan tach stall monitor assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef FAN_TACH_STALL_MONITOR_TOP_ASSERT_SVH
`define FAN_TACH_STALL_MONITOR_TOP_ASSERT_SVH

// same-cycle implication
`define FTSM_ASSERT_IMP(lbl, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (b)) \
		else $error("ftsm assertion failed");

// next-cycle implication
`define FTSM_ASSERT_NXT(lbl, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (b)) \
		else $error("ftsm assertion failed");

`endif

FILE: hdl/ftsm_pkg.sv
// ----------------------------------------------------------------------------
// Fan tach stall monitor package
// Constants, codes and shared types of the monitor.
// ----------------------------------------------------------------------------
package ftsm_pkg;

	localparam int MAX_FANS  = 8;
	localparam int FAN_W     = 3;
	localparam int TIME_BITS = 48;
	localparam int NUM_W     = 58;
	localparam int DEN_W     = 40;
	localparam int CNT_W     = 6;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 32;
	localparam logic [25:0] RPM_SCALE = 26'd60000000;

	localparam logic [1:0] CMD_SAMPLE = 2'd0;
	localparam logic [1:0] CMD_CLEAR  = 2'd1;
	localparam logic [1:0] CMD_QUERY  = 2'd2;
	localparam logic [1:0] CMD_RSVD   = 2'd3;

	localparam logic [1:0] CAUSE_NONE   = 2'd0;
	localparam logic [1:0] CAUSE_STALL  = 2'd1;
	localparam logic [1:0] CAUSE_SENSOR = 2'd2;

	localparam logic [1:0] ACT_ALARM     = 2'd0;
	localparam logic [1:0] ACT_LATCH_ONE = 2'd1;
	localparam logic [1:0] ACT_LATCH_ALL = 2'd2;
	localparam logic [1:0] ACT_UNUSED    = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_ACTION   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COUNT    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PPR      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STALL    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_GRACE    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_INVALID  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_BASE     = 3'd7;

	typedef struct packed {
		logic [1:0]           command;
		logic [FAN_W-1:0]     fan_index;
		logic [TIME_BITS-1:0] now_us;
		logic [31:0]          window_us;
		logic [31:0]          tach_pulses;
		logic                 count_ok;
		logic                 drive_status_ok;
		logic                 drive_on;
		logic [TIME_BITS-1:0] drive_on_since_us;
	} ftsm_item_t;

	typedef struct packed {
		logic [FAN_W-1:0] result_fan;
		logic [8:0]       reported_fan_number;
		logic [31:0]      rpm_value;
		logic             reading_valid;
		logic             alarm_active;
		logic             alarm_latched;
		logic             new_fault;
		logic [1:0]       cause;
		logic [31:0]      fault_count;
		logic [31:0]      generation;
		logic [1:0]       action_taken;
		logic             request_error;
	} ftsm_result_t;

	typedef struct packed {
		logic capture;
		logic div_start;
		logic update;
	} ftsm_cmd_t;

	typedef struct packed {
		logic need_div;
		logic div_done;
		logic out_busy;
	} ftsm_stat_t;

endpackage

FILE: hdl/ftsm_if.sv
// ----------------------------------------------------------------------------
// Fan tach stall monitor channels
// Valid/ready channels for sample items and result items.
// ----------------------------------------------------------------------------
interface ftsm_item_if import ftsm_pkg::*; ();
	logic       valid;
	logic       ready;
	ftsm_item_t item;
	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

interface ftsm_result_if import ftsm_pkg::*; ();
	logic         valid;
	logic         ready;
	ftsm_result_t res;
	modport source (output valid, output res, input ready);
	modport sink (input valid, input res, output ready);
endinterface

FILE: hdl/ftsm_div.sv
// ----------------------------------------------------------------------------
// Fan tach stall monitor divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ftsm_div import ftsm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quo
);

	logic [NUM_W-1:0] n_q;
	logic [DEN_W-1:0] d_q;
	logic [DEN_W:0]   r_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   sh;
	logic             ge;
	logic             last;

	assign sh   = {r_q[DEN_W-1:0], n_q[NUM_W-1]};
	assign ge   = sh >= {1'b0, d_q};
	assign last = cnt_q == CNT_W'(NUM_W - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && last;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last) busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= num;
			d_q <= den;
			r_q <= '0;
		end else if (busy_q) begin
			r_q <= ge ? (sh - {1'b0, d_q}) : sh;
			n_q <= {n_q[NUM_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = n_q;

endmodule

FILE: hdl/ftsm_ctrl.sv
// ----------------------------------------------------------------------------
// Fan tach stall monitor controller
// Sequences capture, division where needed and state update of one item.
// ----------------------------------------------------------------------------
`include "fan_tach_stall_monitor_top_assert.svh"

module ftsm_ctrl import ftsm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  ftsm_stat_t stat,
	output ftsm_cmd_t  cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_CHK  = 2'd1;
	localparam logic [1:0] S_DIV  = 2'd2;
	localparam logic [1:0] S_UPD  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign in_ready = state_q == S_IDLE;

	always_comb begin
		state_d       = state_q;
		cmd.capture   = 1'b0;
		cmd.div_start = 1'b0;
		cmd.update    = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_CHK;
				end
			end
			S_CHK: begin
				if (stat.need_div) begin
					cmd.div_start = 1'b1;
					state_d       = S_DIV;
				end else begin
					state_d = S_UPD;
				end
			end
			S_DIV: begin
				if (stat.div_done) state_d = S_UPD;
			end
			S_UPD: begin
				if (!stat.out_busy) begin
					cmd.update = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`FTSM_ASSERT_NXT(a_accept_leaves_idle, in_valid && in_ready, state_q == S_CHK)
	`FTSM_ASSERT_IMP(a_update_not_blocked, cmd.update, !stat.out_busy)
	`FTSM_ASSERT_NXT(a_start_enters_div, cmd.div_start, state_q == S_DIV)
	`FTSM_ASSERT_IMP(a_done_only_in_div, stat.div_done, state_q == S_DIV)

endmodule

FILE: hdl/ftsm_dp.sv
// ----------------------------------------------------------------------------
// Fan tach stall monitor datapath
// Configuration, per-fan state, rpm arithmetic and result register.
// ----------------------------------------------------------------------------
module ftsm_dp import ftsm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data,
	input  ftsm_item_t           item,
	input  ftsm_cmd_t            cmd,
	output ftsm_stat_t           stat,
	output logic                 out_valid,
	input  logic                 out_ready,
	output ftsm_result_t         res
);

	logic [1:0]  act_q;
	logic [3:0]  count_q;
	logic [7:0]  ppr_q;
	logic [15:0] stall_q;
	logic [31:0] deb_q;
	logic [31:0] grace_q;
	logic [31:0] inval_q;
	logic [7:0]  base_q;

	ftsm_item_t  it_q;

	logic [31:0]          speed_q [MAX_FANS];
	logic [MAX_FANS-1:0]  sval_q;
	logic [MAX_FANS-1:0]  alarm_q;
	logic [MAX_FANS-1:0]  latch_q;
	logic [1:0]           reason_q [MAX_FANS];
	logic [31:0]          total_q [MAX_FANS];
	logic [31:0]          epoch_q [MAX_FANS];
	logic [TIME_BITS-1:0] low_q [MAX_FANS];
	logic [TIME_BITS-1:0] bad_q [MAX_FANS];

	ftsm_result_t res_q;
	ftsm_result_t res_n;
	logic         ovalid_q;

	logic [NUM_W-1:0] num;
	logic [DEN_W-1:0] den;
	logic [NUM_W-1:0] quo;
	logic             div_done;

	logic [3:0]       n_use;
	logic             idx_ok;
	logic [1:0]       act_eff;
	logic [FAN_W-1:0] f;

	logic [31:0]          rpm;
	logic                 grace_done;
	logic                 monitoring;
	logic                 bad;
	logic [31:0]          sp_n;
	logic                 sv_n;
	logic                 al_n;
	logic [MAX_FANS-1:0]  la_n;
	logic [1:0]           rs_n;
	logic [31:0]          tot_n;
	logic [31:0]          ep_n;
	logic [TIME_BITS-1:0] ls_n;
	logic [TIME_BITS-1:0] bs_n;
	logic                 fresh;
	logic                 raise;
	logic [1:0]           why;

	function automatic logic elapsed(input logic [TIME_BITS-1:0] now,
			input logic [TIME_BITS-1:0] since, input logic [31:0] span);
		logic [TIME_BITS-1:0] diff;
		diff = now - since;
		return (now >= since) && (diff >= TIME_BITS'(span));
	endfunction

	function automatic logic [31:0] bump(input logic [31:0] e);
		return (e == 32'hFFFF_FFFF) ? 32'd1 : e + 32'd1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q   <= ACT_ALARM;
			count_q <= 4'd1;
			ppr_q   <= 8'd2;
			stall_q <= 16'd300;
			deb_q   <= 32'd2000000;
			grace_q <= 32'd3000000;
			inval_q <= 32'd300000;
			base_q  <= 8'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ACTION:   act_q   <= cfg_data[1:0];
				REG_COUNT:    count_q <= cfg_data[3:0];
				REG_PPR:      ppr_q   <= cfg_data[7:0];
				REG_STALL:    stall_q <= cfg_data[15:0];
				REG_DEBOUNCE: deb_q   <= cfg_data;
				REG_GRACE:    grace_q <= cfg_data;
				REG_INVALID:  inval_q <= cfg_data;
				REG_BASE:     base_q  <= cfg_data[7:0];
				default:      ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) it_q <= item;
	end

	assign n_use   = (count_q > 4'(MAX_FANS)) ? 4'(MAX_FANS) : count_q;
	assign idx_ok  = {1'b0, it_q.fan_index} < n_use;
	assign act_eff = (act_q == ACT_UNUSED) ? ACT_ALARM : act_q;
	assign f       = it_q.fan_index;

	assign num = NUM_W'(it_q.tach_pulses) * NUM_W'(RPM_SCALE);
	assign den = DEN_W'(it_q.window_us) * DEN_W'(ppr_q);

	ftsm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (num),
		.den    (den),
		.done   (div_done),
		.quo    (quo)
	);

	assign stat.need_div = (it_q.command == CMD_SAMPLE) && it_q.count_ok && idx_ok;
	assign stat.div_done = div_done;
	assign stat.out_busy = ovalid_q && !out_ready;

	always_comb begin
		rpm = 32'd0;
		if (it_q.count_ok && (it_q.window_us != 32'd0) && (ppr_q != 8'd0)) begin
			rpm = (|quo[NUM_W-1:32]) ? 32'hFFFF_FFFF : quo[31:0];
		end
		grace_done = it_q.drive_status_ok && it_q.drive_on &&
			(it_q.drive_on_since_us != '0) &&
			elapsed(it_q.now_us, it_q.drive_on_since_us, grace_q);
		monitoring = it_q.count_ok && grace_done;
		bad        = !it_q.drive_status_ok || (grace_done && !it_q.count_ok);

		sp_n  = speed_q[f];
		sv_n  = sval_q[f];
		al_n  = alarm_q[f];
		la_n  = latch_q;
		rs_n  = reason_q[f];
		tot_n = total_q[f];
		ep_n  = epoch_q[f];
		ls_n  = low_q[f];
		bs_n  = bad_q[f];
		raise = 1'b0;
		why   = CAUSE_NONE;

		case (it_q.command)
			CMD_SAMPLE: begin
				sv_n = it_q.count_ok && it_q.drive_status_ok;
				sp_n = rpm;
				if (bad) begin
					if (bs_n == '0) bs_n = it_q.now_us;
					if (!alarm_q[f] && elapsed(it_q.now_us, bs_n, inval_q)) begin
						raise = 1'b1;
						why   = CAUSE_SENSOR;
					end
				end else if (monitoring && (rpm < {16'd0, stall_q})) begin
					bs_n = '0;
					if (ls_n == '0) ls_n = it_q.now_us;
					if (!alarm_q[f] && elapsed(it_q.now_us, ls_n, deb_q)) begin
						raise = 1'b1;
						why   = CAUSE_STALL;
					end
				end else begin
					bs_n = '0;
					ls_n = '0;
					if (!latch_q[f]) begin
						al_n = 1'b0;
						rs_n = CAUSE_NONE;
					end
				end
			end
			CMD_CLEAR: begin
				al_n    = 1'b0;
				la_n[f] = 1'b0;
				ls_n    = '0;
				bs_n    = '0;
				rs_n    = CAUSE_NONE;
				ep_n    = bump(ep_n);
			end
			default: ;
		endcase

		if (raise) begin
			al_n = 1'b1;
			rs_n = why;
			if (tot_n != 32'hFFFF_FFFF) tot_n = tot_n + 32'd1;
			ep_n = bump(ep_n);
			if (act_eff == ACT_LATCH_ONE) begin
				la_n[f] = 1'b1;
			end else if (act_eff == ACT_LATCH_ALL) begin
				for (int i = 0; i < MAX_FANS; i++) begin
					if (4'(i) < n_use) la_n[i] = 1'b1;
				end
			end
		end
		fresh = raise;

		res_n            = '0;
		res_n.result_fan = it_q.fan_index;
		if (idx_ok) begin
			res_n.reported_fan_number = 9'(base_q) + 9'(it_q.fan_index);
			res_n.rpm_value     = sp_n;
			res_n.reading_valid = sv_n;
			res_n.alarm_active  = al_n;
			res_n.alarm_latched = la_n[f];
			res_n.new_fault     = fresh;
			res_n.cause         = rs_n;
			res_n.fault_count   = tot_n;
			res_n.generation    = ep_n;
			res_n.action_taken  = fresh ? act_eff : ACT_ALARM;
		end else begin
			res_n.request_error = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sval_q  <= '0;
			alarm_q <= '0;
			latch_q <= '0;
			for (int i = 0; i < MAX_FANS; i++) begin
				speed_q[i]  <= '0;
				reason_q[i] <= CAUSE_NONE;
				total_q[i]  <= '0;
				epoch_q[i]  <= '0;
				low_q[i]    <= '0;
				bad_q[i]    <= '0;
			end
		end else if (cmd.update && idx_ok) begin
			speed_q[f]  <= sp_n;
			sval_q[f]   <= sv_n;
			alarm_q[f]  <= al_n;
			latch_q     <= la_n;
			reason_q[f] <= rs_n;
			total_q[f]  <= tot_n;
			epoch_q[f]  <= ep_n;
			low_q[f]    <= ls_n;
			bad_q[f]    <= bs_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (cmd.update) begin
			ovalid_q <= 1'b1;
		end else if (out_ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update) res_q <= res_n;
	end

	assign out_valid = ovalid_q;
	assign res       = res_q;

endmodule

FILE: hdl/fan_tach_stall_monitor_top.sv
// Sequence: a sample is captured on accept; an in-range, valid-count sample then
// passes the bit-serial 58/40-bit divider; other items go straight to update.
// Flow: one item at a time; the next sample is accepted after the update, and
// a held result delays the update and the next accept.
// Reset: arst_n clears configuration to defaults and all per-fan state at once.
// ----------------------------------------------------------------------------
// Fan tach stall monitor top level
// Per-fan tachometer supervisor with stall and sensor fault detection.
// ----------------------------------------------------------------------------
module fan_tach_stall_monitor_top import ftsm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data,
	ftsm_item_if.sink            sample_in,
	ftsm_result_if.source        result_out
);

	ftsm_cmd_t  cmd;
	ftsm_stat_t stat;
	logic       in_ready;

	assign sample_in.ready = in_ready;

	ftsm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sample_in.valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	ftsm_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item      (sample_in.item),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (result_out.valid),
		.out_ready (result_out.ready),
		.res       (result_out.res)
	);

endmodule
